// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the queue and back-end RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A clocked property that is checked outside reset.
`define TAM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("threshold alarm monitor: assertion failed");

// A condition that must never be true outside reset.
`define TAM_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("threshold alarm monitor: forbidden condition seen");

`else

`define TAM_ASSERT(lbl, clk, rstn, prop)
`define TAM_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- rtl/tam_pkg.sv -----
`default_nettype none

package tam_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_WARN_LOW  = 3'd0;
  localparam logic [2:0] REG_WARN_HIGH = 3'd1;
  localparam logic [2:0] REG_FAIL_LOW  = 3'd2;
  localparam logic [2:0] REG_FAIL_HIGH = 3'd3;
  localparam logic [2:0] REG_HYST_BAND = 3'd4;
  localparam logic [2:0] REG_HIT_LIMIT = 3'd5;
  localparam logic [2:0] REG_MODE_BITS = 3'd6;

  localparam int HYST_W   = 31;
  localparam int FRAC_W   = 16;
  // 100.0 in Q16.16.
  localparam int PCT_FULL = 100 << FRAC_W;

  // Reported severity codes.
  localparam logic [1:0] SEV_OKAY = 2'd0;
  localparam logic [1:0] SEV_WARN = 2'd1;
  localparam logic [1:0] SEV_FAIL = 2'd2;

  typedef enum logic [1:0] {
    LV_UNKNOWN = 2'd0,
    LV_OKAY    = 2'd1,
    LV_WARN    = 2'd2,
    LV_FAIL    = 2'd3
  } level_t;

  typedef struct packed {
    logic en_fail_high;
    logic en_fail_low;
    logic en_warn_high;
    logic en_warn_low;
    logic pct;
    logic keep_okay;
    logic persist;
    logic inv;
  } mode_t;

  // Classification of one word, independent of the stored level.
  typedef struct packed {
    logic fail_cross;       // failure limits crossed, no hysteresis
    logic fail_cross_hyst;  // failure limits crossed, hysteresis applied
    logic warn_cross;
    logic warn_cross_hyst;
    logic below_warn;       // raw sample below the enabled warning low limit
    logic below_fail;       // raw sample below the enabled failure low limit
  } class_t;

endpackage

`default_nettype wire

// ----- rtl/threshold_alarm_monitor.sv -----
// Threshold alarm monitor: checks a stream of signed Q16.16 samples against
// warning and failure windows with hysteresis, hit counting and persistence.
// Input channel: in_valid / in_stall carry one word, a sample value and its
// valid bit; the word is taken at an edge where in_valid is high and in_stall
// is low. Result channel: out_valid / out_stall carry a report word with
// severity, direction, limit and a level-changed flag. A sample produces
// zero or one report. Configuration: cfg_we writes cfg_wdata to the register
// selected by cfg_index (warning low/high, failure low/high, hysteresis band,
// hit limit, mode bits); write it only while the monitor is idle.
// An accepted word is written into the queue, and the back end moves its report
// into the report register that drives out_valid. One word is taken per cycle
// while the queue has room: a front classifier compares each sample against all
// limits with and without hysteresis, a two-word queue holds the result, and
// the back end updates the stored level and hit counter for each word it takes.
// Reset (rst_n low, synchronous) clears the stored level to unknown, the hit
// counter, the queue, and all configuration registers. When the receiver
// stalls, the report register holds its word, the queue fills, and in_stall
// rises after two further words.
`default_nettype none

module threshold_alarm_monitor #(
  parameter int VALUE_WIDTH = 32,
  parameter int HIT_WIDTH   = 16,
  // Configuration data is as wide as the widest register.
  localparam int WIDE_W = (VALUE_WIDTH > tam_pkg::HYST_W) ? VALUE_WIDTH : tam_pkg::HYST_W,
  localparam int CFG_W  = (WIDE_W > HIT_WIDTH) ? WIDE_W : HIT_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [VALUE_WIDTH-1:0] in_sample_value,
  input  wire logic                          in_sample_valid,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_severity,
  output logic                               out_below_limit,
  output logic signed [VALUE_WIDTH-1:0]      out_limit_value,
  output logic                               out_level_changed,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_wdata
);

  logic signed [VALUE_WIDTH-1:0]   warn_low_r, warn_high_r, fail_low_r, fail_high_r;
  logic [tam_pkg::HYST_W-1:0]      hyst_r;
  logic [HIT_WIDTH-1:0]            hit_limit_r;
  tam_pkg::mode_t                  mode_r;

  tam_pkg::class_t                 cls;
  tam_pkg::class_t                 q_data;
  logic                            q_full, q_not_empty, q_pop, q_push;

  // Register file. Indexes beyond the mode register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_low_r  <= '0;
      warn_high_r <= '0;
      fail_low_r  <= '0;
      fail_high_r <= '0;
      hyst_r      <= '0;
      hit_limit_r <= '0;
      mode_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tam_pkg::REG_WARN_LOW:  warn_low_r  <= cfg_wdata[VALUE_WIDTH-1:0];
        tam_pkg::REG_WARN_HIGH: warn_high_r <= cfg_wdata[VALUE_WIDTH-1:0];
        tam_pkg::REG_FAIL_LOW:  fail_low_r  <= cfg_wdata[VALUE_WIDTH-1:0];
        tam_pkg::REG_FAIL_HIGH: fail_high_r <= cfg_wdata[VALUE_WIDTH-1:0];
        tam_pkg::REG_HYST_BAND: hyst_r      <= cfg_wdata[tam_pkg::HYST_W-1:0];
        tam_pkg::REG_HIT_LIMIT: hit_limit_r <= cfg_wdata[HIT_WIDTH-1:0];
        tam_pkg::REG_MODE_BITS: mode_r      <= tam_pkg::mode_t'(cfg_wdata[7:0]);
        default: ;
      endcase
    end
  end

  // The front end is ready whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  tam_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .sample_value (in_sample_value),
    .sample_valid (in_sample_valid),
    .warn_low     (warn_low_r),
    .warn_high    (warn_high_r),
    .fail_low     (fail_low_r),
    .fail_high    (fail_high_r),
    .hyst_band    (hyst_r),
    .mode         (mode_r),
    .cls          (cls)
  );

  tam_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  tam_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .HIT_WIDTH   (HIT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .warn_low          (warn_low_r),
    .warn_high         (warn_high_r),
    .fail_low          (fail_low_r),
    .fail_high         (fail_high_r),
    .hit_limit         (hit_limit_r),
    .mode              (mode_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_severity      (out_severity),
    .out_below_limit   (out_below_limit),
    .out_limit_value   (out_limit_value),
    .out_level_changed (out_level_changed)
  );

endmodule

`default_nettype wire

// ----- rtl/tam_front.sv -----
`default_nettype none

module tam_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic signed [VALUE_WIDTH-1:0] sample_value,
  input  wire logic                          sample_valid,
  input  wire logic signed [VALUE_WIDTH-1:0] warn_low,
  input  wire logic signed [VALUE_WIDTH-1:0] warn_high,
  input  wire logic signed [VALUE_WIDTH-1:0] fail_low,
  input  wire logic signed [VALUE_WIDTH-1:0] fail_high,
  input  wire logic [tam_pkg::HYST_W-1:0]    hyst_band,
  input  wire tam_pkg::mode_t                mode,
  output tam_pkg::class_t                    cls
);

  // Wide enough for the difference of two limits, the percentage constant
  // and the hysteresis band taken as a positive number.
  localparam int CMP_W = ((VALUE_WIDTH > tam_pkg::HYST_W) ? VALUE_WIDTH
                                                          : tam_pkg::HYST_W) + 2;

  logic                    chk_ok;
  logic signed [CMP_W-1:0] chk_v;
  logic signed [CMP_W-1:0] h_ext;
  logic signed [CMP_W-1:0] d_wl, d_wh, d_fl, d_fh;

  always_comb begin
    chk_ok = sample_valid;
    chk_v  = CMP_W'(sample_value);
    if (mode.pct) begin
      if (sample_valid && (sample_value != '0)) begin
        chk_v = CMP_W'(tam_pkg::PCT_FULL);
      end else begin
        chk_ok = 1'b0;
      end
    end
  end

  assign h_ext = $signed({{(CMP_W-tam_pkg::HYST_W){1'b0}}, hyst_band});

  // Distance from each limit toward the inside of the window.
  assign d_wl = chk_v - CMP_W'(warn_low);
  assign d_wh = CMP_W'(warn_high) - chk_v;
  assign d_fl = chk_v - CMP_W'(fail_low);
  assign d_fh = CMP_W'(fail_high) - chk_v;

  always_comb begin
    cls.fail_cross = chk_ok &&
                     ((mode.en_fail_low  && (d_fl < 0)) ||
                      (mode.en_fail_high && (d_fh < 0)));
    cls.fail_cross_hyst = chk_ok &&
                          ((mode.en_fail_low  && (d_fl < h_ext)) ||
                           (mode.en_fail_high && (d_fh < h_ext)));
    cls.warn_cross = chk_ok &&
                     ((mode.en_warn_low  && (d_wl < 0)) ||
                      (mode.en_warn_high && (d_wh < 0)));
    cls.warn_cross_hyst = chk_ok &&
                          ((mode.en_warn_low  && (d_wl < h_ext)) ||
                           (mode.en_warn_high && (d_wh < h_ext)));
    cls.below_warn = sample_valid && mode.en_warn_low && (sample_value < warn_low);
    cls.below_fail = sample_valid && mode.en_fail_low && (sample_value < fail_low);
  end

endmodule

`default_nettype wire

// ----- rtl/tam_queue.sv -----
`default_nettype none
`include "assert_macros.svh"

module tam_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tam_pkg::class_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output tam_pkg::class_t      pop_data
);

  tam_pkg::class_t entry_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `TAM_NEVER(a_no_push_when_full, clk, rst_n, push && full)
  `TAM_NEVER(a_no_pop_when_empty, clk, rst_n, pop && !not_empty)

endmodule

`default_nettype wire

// ----- rtl/tam_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module tam_back #(
  parameter int VALUE_WIDTH = 32,
  parameter int HIT_WIDTH   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_not_empty,
  input  wire tam_pkg::class_t               q_data,
  output logic                               q_pop,
  input  wire logic signed [VALUE_WIDTH-1:0] warn_low,
  input  wire logic signed [VALUE_WIDTH-1:0] warn_high,
  input  wire logic signed [VALUE_WIDTH-1:0] fail_low,
  input  wire logic signed [VALUE_WIDTH-1:0] fail_high,
  input  wire logic [HIT_WIDTH-1:0]          hit_limit,
  input  wire tam_pkg::mode_t                mode,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_severity,
  output logic                               out_below_limit,
  output logic signed [VALUE_WIDTH-1:0]      out_limit_value,
  output logic                               out_level_changed
);

  tam_pkg::level_t               lvl_r, lvl_nxt;
  logic [HIT_WIDTH:0]            hit_r, hit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    sev_r, sev_nxt;
  logic                          below_r, below_nxt;
  logic signed [VALUE_WIDTH-1:0] limit_r, limit_nxt;
  logic                          changed_r, changed_nxt;

  logic                          fail_hit, warn_hit;
  tam_pkg::level_t               new_lvl;
  logic                          report;
  logic                          lo_en, hi_en, raw_below;
  logic signed [VALUE_WIDTH-1:0] lo_lim, hi_lim;

  // The output register takes a new word when it is empty or being drained.
  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  always_comb begin
    fail_hit = (lvl_r == tam_pkg::LV_FAIL) ? q_data.fail_cross_hyst : q_data.fail_cross;
    warn_hit = (lvl_r == tam_pkg::LV_WARN) ? q_data.warn_cross_hyst : q_data.warn_cross;
    fail_hit = fail_hit ^ mode.inv;
    warn_hit = warn_hit ^ mode.inv;
    if (fail_hit) begin
      new_lvl = tam_pkg::LV_FAIL;
    end else if (warn_hit) begin
      new_lvl = tam_pkg::LV_WARN;
    end else begin
      new_lvl = tam_pkg::LV_OKAY;
    end
  end

  always_comb begin
    report  = 1'b1;
    hit_nxt = hit_r;
    if (hit_limit != '0) begin
      if (((new_lvl == tam_pkg::LV_OKAY) && !mode.keep_okay) ||
          (hit_r > {1'b0, hit_limit})) begin
        hit_nxt = '0;
      end else begin
        hit_nxt = hit_r + 1'b1;
        report  = 1'b0;
      end
    end
    if (report && (new_lvl == lvl_r)) begin
      if (!mode.persist || ((new_lvl == tam_pkg::LV_OKAY) && !mode.keep_okay)) begin
        report = 1'b0;
      end
    end
    lvl_nxt = report ? new_lvl : lvl_r;
    if (!q_pop) begin
      hit_nxt = hit_r;
      lvl_nxt = lvl_r;
    end
  end

  // Direction, reported limit, severity and level-changed flag for the new level.
  always_comb begin
    lo_en     = (new_lvl == tam_pkg::LV_FAIL) ? mode.en_fail_low  : mode.en_warn_low;
    hi_en     = (new_lvl == tam_pkg::LV_FAIL) ? mode.en_fail_high : mode.en_warn_high;
    lo_lim    = (new_lvl == tam_pkg::LV_FAIL) ? fail_low  : warn_low;
    hi_lim    = (new_lvl == tam_pkg::LV_FAIL) ? fail_high : warn_high;
    raw_below = (new_lvl == tam_pkg::LV_FAIL) ? q_data.below_fail : q_data.below_warn;
    below_nxt = 1'b0;
    limit_nxt = '0;
    if (new_lvl != tam_pkg::LV_OKAY) begin
      if (mode.inv && !(lo_en && hi_en)) begin
        if (!lo_en) begin
          below_nxt = 1'b1;
          limit_nxt = hi_en ? hi_lim : '0;
        end else begin
          limit_nxt = lo_lim;
        end
      end else if (raw_below) begin
        below_nxt = 1'b1;
        limit_nxt = lo_lim;
      end else begin
        limit_nxt = hi_en ? hi_lim : '0;
      end
    end
    unique case (new_lvl)
      tam_pkg::LV_FAIL: sev_nxt = tam_pkg::SEV_FAIL;
      tam_pkg::LV_WARN: sev_nxt = tam_pkg::SEV_WARN;
      default:          sev_nxt = tam_pkg::SEV_OKAY;
    endcase
    changed_nxt = (new_lvl != lvl_r);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = report;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r       <= tam_pkg::LV_UNKNOWN;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lvl_r       <= lvl_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && report) begin
      sev_r     <= sev_nxt;
      below_r   <= below_nxt;
      limit_r   <= limit_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_severity      = sev_r;
  assign out_below_limit   = below_r;
  assign out_limit_value   = limit_r;
  assign out_level_changed = changed_r;

  `TAM_ASSERT(a_okay_report_clean, clk, rst_n,
    (out_valid_r && (sev_r == tam_pkg::SEV_OKAY)) |-> (!below_r && (limit_r == '0)))
  `TAM_ASSERT(a_level_known_stays, clk, rst_n,
    (lvl_r != tam_pkg::LV_UNKNOWN) |=> (lvl_r != tam_pkg::LV_UNKNOWN))
  `TAM_ASSERT(a_word_from_queue, clk, rst_n, $rose(out_valid_r) |-> $past(q_pop))

endmodule

`default_nettype wire
